// ----- rtl/gpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// gpsm_pkg
// Shared types and constants of the glob pattern stream matcher: special
// pattern bytes, configuration register indexes and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package gpsm_pkg;

	// Configuration port geometry.
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int LEN_W       = 6;
	localparam int BYTES_PER_REG = CFG_DATA_W / 8;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_A = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_B = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_C = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_D = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH  = 3'd4;

	// Pattern bytes with a special meaning.
	localparam logic [7:0] CHAR_BAR   = 8'h7C;
	localparam logic [7:0] CHAR_QUERY = 8'h3F;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic [7:0] character;
		logic       end_of_string;
		logic       is_slash;
	} queue_entry_t;

	// Write side of the queue.
	typedef struct packed {
		logic         valid;
		queue_entry_t entry;
	} queue_wr_t;

	// Head of the queue as the back sees it.
	typedef struct packed {
		logic         valid;
		queue_entry_t entry;
	} queue_rd_t;

endpackage

`default_nettype wire

// ----- rtl/gpsm_intf.sv -----
// ----------------------------------------------------------------------------
// gpsm_intf
// Valid/ready channels of the matcher: the byte stream and the match result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpsm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       end_of_string;

	modport source (output valid, output character, output end_of_string, input ready);
	modport sink   (input valid, input character, input end_of_string, output ready);
endinterface

interface gpsm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink   (input valid, input matched, output ready);
endinterface

`default_nettype wire

// ----- rtl/gpsm_front.sv -----
// ----------------------------------------------------------------------------
// gpsm_front
// Holds the pattern registers, accepts byte stream requests and classifies
// each one before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsm_front
	import gpsm_pkg::*;
#(
	parameter int PATTERN_MAX = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	gpsm_in_if.sink                    byte_stream,
	input  wire                        cfg_we,
	input  wire  [CFG_INDEX_W-1:0]     cfg_index,
	input  wire  [CFG_DATA_W-1:0]      cfg_wdata,
	output queue_wr_t                  q_wr,
	input  wire                        q_ready,
	output logic [PATTERN_MAX-1:0][7:0] pattern,
	output logic [LEN_W-1:0]           used_len,
	output logic                       rearm
);

	logic [PATTERN_MAX-1:0][7:0] pattern_q;
	logic [LEN_W-1:0]            length_q;

	// Pattern bytes: each byte belongs to one of the four byte registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
		end else if (cfg_we) begin
			for (int b = 0; b < PATTERN_MAX; b++) begin
				if (cfg_index == CFG_INDEX_W'(b / BYTES_PER_REG)) begin
					pattern_q[b] <= cfg_wdata[(b % BYTES_PER_REG) * 8 +: 8];
				end
			end
		end
	end

	// Pattern length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cfg_we && cfg_index == REG_LENGTH) begin
			length_q <= cfg_wdata[LEN_W-1:0];
		end
	end

	// A length beyond the pattern store counts as the full store.
	assign used_len = (length_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : length_q;
	assign pattern  = pattern_q;

	// Any write to a defined register re-arms the matcher.
	assign rearm = cfg_we && (cfg_index <= REG_LENGTH);

	// Classify the request and hand it to the queue.
	assign q_wr.valid               = byte_stream.valid;
	assign q_wr.entry.character     = byte_stream.character;
	assign q_wr.entry.end_of_string = byte_stream.end_of_string;
	assign q_wr.entry.is_slash      = (byte_stream.character == CHAR_SLASH);
	assign byte_stream.ready        = q_ready;

endmodule

`default_nettype wire

// ----- rtl/gpsm_queue.sv -----
// ----------------------------------------------------------------------------
// gpsm_queue
// Two-entry queue that decouples the front from the back: a stall on one
// side holds up the other only once the queue fills or drains.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsm_queue
	import gpsm_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  queue_wr_t  q_wr,
	output logic       q_ready,
	output queue_rd_t  q_rd,
	input  wire        q_pop
);

	queue_entry_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]         wr_ptr_q;
	logic [QPTR_W-1:0]         rd_ptr_q;
	logic [QCNT_W-1:0]         count_q;
	logic                      push;
	logic                      pop;

	assign q_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push    = q_wr.valid && q_ready;
	assign pop     = q_pop && (count_q != '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= q_wr.entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Head of the queue.
	assign q_rd.valid = (count_q != '0);
	assign q_rd.entry = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- rtl/gpsm_back.sv -----
// ----------------------------------------------------------------------------
// gpsm_back
// Applies queued requests to the set of active pattern positions and
// delivers the match result on each end of string through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsm_back
	import gpsm_pkg::*;
#(
	parameter int PATTERN_MAX = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  queue_rd_t                   q_rd,
	output logic                        q_pop,
	input  wire  [PATTERN_MAX-1:0][7:0] pattern,
	input  wire  [LEN_W-1:0]            used_len,
	input  wire                         rearm,
	gpsm_out_if.source                  match_result
);

	localparam int NPOS = PATTERN_MAX + 1;

	logic [NPOS-1:0]        active_q;
	logic                   fresh_q;
	logic                   out_valid_q;
	logic                   out_matched_q;

	logic [PATTERN_MAX-1:0] in_use;
	logic [PATTERN_MAX-1:0] is_star;
	logic [PATTERN_MAX-1:0] is_dbl;
	logic [PATTERN_MAX-1:0] is_bar;
	logic [PATTERN_MAX-1:0] is_lit_hit;
	logic [NPOS-1:0]        start_pos;
	logic [NPOS-1:0]        end_pos;
	logic [NPOS-1:0]        cur;
	logic [NPOS-1:0]        closed;
	logic [NPOS-1:0]        next_pos;
	logic                   hit;
	logic                   out_free;

	// Decode every pattern position against the used length and the byte.
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			in_use[i]     = (LEN_W'(i) < used_len);
			is_star[i]    = in_use[i] && (pattern[i] == CHAR_STAR);
			is_bar[i]     = in_use[i] && (pattern[i] == CHAR_BAR);
			is_lit_hit[i] = in_use[i] && !is_star[i] && !is_bar[i] &&
				((pattern[i] == CHAR_QUERY) || (pattern[i] == q_rd.entry.character));
		end
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (i + 1 < PATTERN_MAX) begin
				is_dbl[i] = is_star[i] && is_star[i+1];
			end else begin
				is_dbl[i] = 1'b0;
			end
		end
	end

	// Start positions and accepting positions of every alternative.
	always_comb begin
		start_pos    = '0;
		start_pos[0] = 1'b1;
		end_pos      = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			start_pos[i+1] = is_bar[i];
			end_pos[i]     = is_bar[i] || (LEN_W'(i) == used_len);
		end
		end_pos[PATTERN_MAX] = (LEN_W'(PATTERN_MAX) == used_len);
	end

	assign cur = fresh_q ? start_pos : active_q;

	// Let each live star also stand for an empty run; this ripples forward
	// through a run of stars much like a carry chain.
	always_comb begin
		closed    = '0;
		closed[0] = cur[0];
		for (int p = 1; p < NPOS; p++) begin
			closed[p] = cur[p] || (closed[p-1] && is_star[p-1] && !is_dbl[p-1]);
			if (p >= 2) begin
				closed[p] = closed[p] || (closed[p-2] && is_dbl[p-2]);
			end
		end
	end

	// Consume one byte: stars hold their place (a single star not on a slash), literals advance by one.
	always_comb begin
		next_pos = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (closed[i] && is_star[i] && (is_dbl[i] || !q_rd.entry.is_slash)) begin
				next_pos[i] = 1'b1;
			end
			if (closed[i] && is_lit_hit[i]) begin
				next_pos[i+1] = 1'b1;
			end
		end
	end

	assign hit = |(closed & end_pos);

	// An end of string needs room in the output register; a byte never waits.
	assign out_free = !out_valid_q || match_result.ready;
	assign q_pop    = q_rd.valid && (!q_rd.entry.end_of_string || out_free);

	// Active position set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q  <= 1'b1;
			active_q <= '0;
		end else if (rearm) begin
			fresh_q <= 1'b1;
		end else if (q_pop) begin
			if (q_rd.entry.end_of_string) begin
				fresh_q <= 1'b1;
			end else begin
				fresh_q  <= 1'b0;
				active_q <= next_pos;
			end
		end
	end

	// Output register for the match result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && q_rd.entry.end_of_string) begin
			out_valid_q <= 1'b1;
		end else if (match_result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_rd.entry.end_of_string) begin
			out_matched_q <= hit;
		end
	end

	assign match_result.valid   = out_valid_q;
	assign match_result.matched = out_matched_q;

endmodule

`default_nettype wire

// ----- rtl/glob_pattern_stream_matcher.sv -----
// ----------------------------------------------------------------------------
// glob_pattern_stream_matcher
// Anchored glob matcher over a byte stream, with '|' alternatives, '?', '*'
// and '**', tracked as a bit-parallel set of live pattern positions.
// ----------------------------------------------------------------------------
//  Channel       Dir  Handshake          Payload
//  byte_stream   in   valid/ready        character[7:0], end_of_string
//  match_result  out  valid/ready        matched (one per end of string)
//  cfg           in   cfg_we, no stall   cfg_index[2:0], cfg_wdata[63:0]
//
// One request is taken per cycle while the queue has room. A request waits in
// the queue and is applied to the active positions when it is popped; the
// result of an end of string is then held in the output register. The position
// update is combinational, including the forward ripple through runs of stars, and sets this rate.
// Reset clears the pattern to zero length; no clearing pass is needed.
// A stalled result stalls only end of string requests; bytes keep flowing
// until the two-entry queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_pattern_stream_matcher
	import gpsm_pkg::*;
#(
	parameter int PATTERN_MAX = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	gpsm_in_if.sink                byte_stream,
	gpsm_out_if.source             match_result,
	input  wire                    cfg_we,
	input  wire [CFG_INDEX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_wdata
);

	queue_wr_t                   q_wr;
	queue_rd_t                   q_rd;
	logic                        q_ready;
	logic                        q_pop;
	logic [PATTERN_MAX-1:0][7:0] pattern;
	logic [LEN_W-1:0]            used_len;
	logic                        rearm;

	// Front: pattern registers and request classification.
	gpsm_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_stream),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.q_wr       (q_wr),
		.q_ready    (q_ready),
		.pattern    (pattern),
		.used_len   (used_len),
		.rearm      (rearm)
	);

	// Queue between the two halves.
	gpsm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_ready(q_ready),
		.q_rd   (q_rd),
		.q_pop  (q_pop)
	);

	// Back: position update and result delivery.
	gpsm_back #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_rd        (q_rd),
		.q_pop       (q_pop),
		.pattern     (pattern),
		.used_len    (used_len),
		.rearm       (rearm),
		.match_result(match_result)
	);

endmodule

`default_nettype wire
